// ----- hdl/gspcd_pkg.sv -----
package gspcd_pkg;

    // Field and state widths.
    localparam int TEMP_W    = 16;
    localparam int PRES_W    = 11;
    localparam int FRAC_BITS = 8;
    localparam int SMOOTH_W  = TEMP_W + FRAC_BITS;
    localparam int ALPHA_W   = 16;
    localparam int PEAK_W_W  = 15;
    localparam int WHOLE_W   = 8;
    localparam int BAR_W     = 8;
    localparam int BAR_U_W   = 13;

    // Smoothing coefficient for both temperature channels, 0.1 in Q0.16.
    localparam logic [ALPHA_W-1:0] ALPHA_TEMP = 16'd6554;

    // Oil temperature limits in hundredths of a degree.
    localparam logic signed [TEMP_W-1:0] FAULT_LIMIT = 16'sd19900;
    localparam logic signed [TEMP_W-1:0] ALERT_LIMIT = 16'sd12000;
    localparam logic signed [TEMP_W-1:0] BAR_LOW     = 16'sd8000;
    localparam int BAR_RANGE = 5000;
    localparam int BAR_SHIFT = 25;

    // Change deadbands in hundredths.
    localparam int DEADBAND_FINE = 5;
    localparam int DEADBAND_OIL  = 10;

    // Division by 100 for oil readings below the fault limit: (x * 5243) >> 19.
    localparam logic [12:0] OIL_DIV_MUL   = 13'd5243;
    localparam int          OIL_DIV_SHIFT = 19;

    // Configuration register indexes and reset values.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ALPHA   = 2'd0;
    localparam t_cfg_idx CFG_PMAX    = 2'd1;
    localparam t_cfg_idx CFG_PRESENT = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;
    localparam logic [PRES_W-1:0]  PMAX_RESET  = 11'd2000;

    // Control for one smoothing channel.
    typedef struct packed {
        logic update;
        logic seed;
    } t_ema_ctl;

    // Shown value: floor((s + 128) / 256), low 16 bits.
    function automatic logic signed [TEMP_W-1:0] f_shown(
        input logic signed [SMOOTH_W-1:0] s
    );
        logic signed [SMOOTH_W:0] t;
        t = {s[SMOOTH_W-1], s} + (SMOOTH_W+1)'(1 << (FRAC_BITS - 1));
        return t[SMOOTH_W-1:FRAC_BITS];
    endfunction

endpackage

// ----- hdl/gspcd_ema.sv -----
module gspcd_ema (
    input  logic                                     i_clk,
    input  gspcd_pkg::t_ema_ctl                      i_ctl,
    input  logic signed [gspcd_pkg::TEMP_W-1:0]      i_x,
    input  logic        [gspcd_pkg::ALPHA_W-1:0]     i_alpha,
    output logic signed [gspcd_pkg::SMOOTH_W-1:0]    o_state
);
    import gspcd_pkg::*;

    localparam int DIFF_W = SMOOTH_W + 1;
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;

    logic signed [SMOOTH_W-1:0] r_s;
    logic signed [SMOOTH_W-1:0] n_s;
    logic signed [SMOOTH_W-1:0] x_scaled;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [PROD_W-1:0]   step;

    // One smoothing step: s += round(alpha * (x*256 - s) / 65536), ties upward.
    always_comb begin
        x_scaled = {i_x, {FRAC_BITS{1'b0}}};
        diff     = {x_scaled[SMOOTH_W-1], x_scaled} - {r_s[SMOOTH_W-1], r_s};
        prod     = diff * $signed({1'b0, i_alpha});
        rounded  = prod + PROD_W'(1 << (ALPHA_W - 1));
        step     = rounded >>> ALPHA_W;
        if (i_ctl.seed) begin
            n_s = x_scaled;
        end else begin
            n_s = r_s + step[SMOOTH_W-1:0];
        end
    end

    // The state moves once per item; the first item seeds it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.update) begin
            r_s <= n_s;
        end
    end

    assign o_state = r_s;

endmodule

// ----- hdl/gauge_smooth_peak_change_detect.sv -----
// A request accepted into stage 1 moves through stages 2 and 3 to the stage 4 output register.
// Throughput: one request per cycle while the output does not stall; each channel's smoother
// state closes its loop through one 16 x 25 bit multiply, so items follow back to back.
// An output stall holds each occupied stage; empty stages still fill.
// Reset (synchronous, active low) empties the pipeline, clears the seed flag, peaks
// and reported values, and returns the configuration registers to their defaults.
module gauge_smooth_peak_change_detect #(
    parameter int BAR_SPAN_PIXELS = 210
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Sample channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic        [gspcd_pkg::PRES_W-1:0]    i_pressure_avg,
    input  logic signed [gspcd_pkg::TEMP_W-1:0]    i_water_avg,
    input  logic signed [gspcd_pkg::TEMP_W-1:0]    i_oil_avg,
    // Result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic        [gspcd_pkg::PRES_W-1:0]    o_pressure_shown,
    output logic signed [gspcd_pkg::TEMP_W-1:0]    o_water_shown,
    output logic signed [gspcd_pkg::TEMP_W-1:0]    o_oil_shown,
    output logic        [gspcd_pkg::WHOLE_W-1:0]   o_oil_peak_whole,
    output logic        [gspcd_pkg::PRES_W-1:0]    o_pressure_peak,
    output logic        [gspcd_pkg::PEAK_W_W-1:0]  o_water_peak,
    output logic                                   o_oil_changed,
    output logic                                   o_pressure_changed,
    output logic                                   o_water_changed,
    output logic        [gspcd_pkg::BAR_W-1:0]     o_oil_bar_width,
    output logic                                   o_oil_alert,
    output logic                                   o_oil_fault,
    // Configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  gspcd_pkg::t_cfg_idx                    i_cfg_index,
    input  logic        [gspcd_pkg::ALPHA_W-1:0]   i_cfg_data
);
    import gspcd_pkg::*;

    // Bar width by reciprocal: floor(u * BAR_MUL / 2^25) equals floor(W * u / 5000)
    // for every u below 5000.
    localparam longint BAR_MUL =
        ((longint'(BAR_SPAN_PIXELS) << BAR_SHIFT) + longint'(BAR_RANGE) - 1) /
        longint'(BAR_RANGE);
    localparam int BAR_MUL_W = $clog2(BAR_MUL + 1);
    localparam int BAR_PROD_W = BAR_U_W + BAR_MUL_W;
    localparam int BAR_Q_W = BAR_PROD_W - BAR_SHIFT;
    localparam int BAR_QX_W = (BAR_Q_W > BAR_W) ? BAR_Q_W : BAR_W;
    localparam logic [BAR_W-1:0] BAR_FULL =
        (BAR_SPAN_PIXELS > 255) ? 8'd255 : BAR_W'(BAR_SPAN_PIXELS);

    // Configuration registers.
    logic [ALPHA_W-1:0] r_alpha;
    logic [PRES_W-1:0]  r_pmax;
    logic               r_present;

    // Stage enables.
    logic e1, e2, e3, e4;

    // Stage 1: captured sample.
    logic                     r1_vld;
    logic [PRES_W-1:0]        r1_p;
    logic signed [TEMP_W-1:0] r1_w;
    logic signed [TEMP_W-1:0] r1_o;

    // Stage 2: smoother state and raw peaks.
    logic                       r2_vld;
    logic                       r_seeded;
    logic [PRES_W-1:0]          r_peak_p;
    logic [WHOLE_W-1:0]         r_peak_o;
    logic [PRES_W-1:0]          n_peak_p;
    logic [WHOLE_W-1:0]         n_peak_o;
    logic                       oil_ok;
    logic [27:0]                whole_prod;
    logic [WHOLE_W-1:0]         whole;
    t_ema_ctl                   ema_ctl;
    logic signed [SMOOTH_W-1:0] s_p, s_w, s_o;

    // Stage 3: shown values, change flags, derived oil flags.
    logic                     r3_vld;
    logic [PRES_W-1:0]        r3_ps;
    logic signed [TEMP_W-1:0] r3_ws;
    logic signed [TEMP_W-1:0] r3_os;
    logic [WHOLE_W-1:0]       r3_pk_o;
    logic [PRES_W-1:0]        r3_pk_p;
    logic [PEAK_W_W-1:0]      r3_pk_w;
    logic                     r3_oc, r3_pc, r3_wc;
    logic                     r3_alert, r3_fault;
    logic                     r3_bar_on, r3_bar_sat;
    logic [BAR_U_W-1:0]       r3_bar_u;

    logic [PEAK_W_W-1:0]      r_peak_w;
    logic [PEAK_W_W-1:0]      n_peak_w;
    logic [PRES_W-1:0]        r_rep_p;
    logic signed [TEMP_W-1:0] r_rep_w;
    logic signed [TEMP_W-1:0] r_rep_o;
    logic [WHOLE_W-1:0]       r_rep_pk;
    logic [2:0]               r_rep_vld;

    logic signed [TEMP_W-1:0] sh_p, sh_w, sh_o;
    logic [PRES_W-1:0]        ps;
    logic signed [TEMP_W-1:0] os;
    logic signed [PRES_W:0]   dp;
    logic signed [TEMP_W:0]   dw, d_o;
    logic                     oc, pc, wc;
    logic                     fault, alert, bar_on, bar_sat;
    logic signed [TEMP_W-1:0] bar_u;

    // Stage 4: output register.
    logic                     r4_vld;
    logic [PRES_W-1:0]        r4_ps;
    logic signed [TEMP_W-1:0] r4_ws;
    logic signed [TEMP_W-1:0] r4_os;
    logic [WHOLE_W-1:0]       r4_pk_o;
    logic [PRES_W-1:0]        r4_pk_p;
    logic [PEAK_W_W-1:0]      r4_pk_w;
    logic                     r4_oc, r4_pc, r4_wc;
    logic [BAR_W-1:0]         r4_bar;
    logic                     r4_alert, r4_fault;

    logic [BAR_PROD_W-1:0]    bar_prod;
    logic [BAR_QX_W-1:0]      bar_q;
    logic [BAR_W-1:0]         n_bar;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= ALPHA_RESET;
            r_pmax    <= PMAX_RESET;
            r_present <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA:   r_alpha   <= i_cfg_data;
                CFG_PMAX:    r_pmax    <= i_cfg_data[PRES_W-1:0];
                CFG_PRESENT: r_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A stage takes a new request when it is empty or its content moves on.
    assign e4 = !r4_vld || !i_out_stall;
    assign e3 = !r3_vld || e4;
    assign e2 = !r2_vld || e3;
    assign e1 = !r1_vld || e2;
    assign o_in_stall = !e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (e1) r1_vld <= i_in_valid;
            if (e2) r2_vld <= r1_vld;
            if (e3) r3_vld <= r2_vld;
            if (e4) r4_vld <= r3_vld;
        end
    end

    // Stage 1: capture with the pressure ceiling applied.
    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_p <= (i_pressure_avg > r_pmax) ? r_pmax : i_pressure_avg;
            r1_w <= i_water_avg;
            r1_o <= i_oil_avg;
        end
    end

    // Stage 2: smoothers and raw peak holds.
    assign ema_ctl.update = r1_vld && e2;
    assign ema_ctl.seed   = !r_seeded;

    gspcd_ema u_ema_p (
        .i_clk   (i_clk),
        .i_ctl   (ema_ctl),
        .i_x     ($signed({{(TEMP_W - PRES_W){1'b0}}, r1_p})),
        .i_alpha (r_alpha),
        .o_state (s_p)
    );

    gspcd_ema u_ema_w (
        .i_clk   (i_clk),
        .i_ctl   (ema_ctl),
        .i_x     (r1_w),
        .i_alpha (ALPHA_TEMP),
        .o_state (s_w)
    );

    gspcd_ema u_ema_o (
        .i_clk   (i_clk),
        .i_ctl   (ema_ctl),
        .i_x     (r1_o),
        .i_alpha (ALPHA_TEMP),
        .o_state (s_o)
    );

    // Negative readings never raise the whole-degree peak, so only 0..198.99 C count.
    always_comb begin
        oil_ok     = !r1_o[TEMP_W-1] && (r1_o < FAULT_LIMIT);
        whole_prod = r1_o[TEMP_W-2:0] * OIL_DIV_MUL;
        whole      = whole_prod[OIL_DIV_SHIFT +: WHOLE_W];
        n_peak_o   = (oil_ok && (whole > r_peak_o)) ? whole : r_peak_o;
        n_peak_p   = (r1_p > r_peak_p) ? r1_p : r_peak_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_peak_p <= '0;
            r_peak_o <= '0;
        end else if (ema_ctl.update) begin
            r_seeded <= 1'b1;
            r_peak_p <= n_peak_p;
            r_peak_o <= n_peak_o;
        end
    end

    // Stage 3: shown values and change detection against the last report.
    always_comb begin
        sh_p = f_shown(s_p);
        sh_w = f_shown(s_w);
        sh_o = f_shown(s_o);
        ps   = sh_p[PRES_W-1:0];
        os   = r_present ? sh_o : '0;

        n_peak_w = (sh_w > $signed({1'b0, r_peak_w})) ? sh_w[PEAK_W_W-1:0] : r_peak_w;

        dp  = $signed({1'b0, ps}) - $signed({1'b0, r_rep_p});
        dw  = {sh_w[TEMP_W-1], sh_w} - {r_rep_w[TEMP_W-1], r_rep_w};
        d_o = {os[TEMP_W-1], os} - {r_rep_o[TEMP_W-1], r_rep_o};

        oc = !r_rep_vld[0] || (d_o >= DEADBAND_OIL) || (d_o <= -DEADBAND_OIL) ||
             (r_peak_o != r_rep_pk);
        pc = !r_rep_vld[1] || (dp >= DEADBAND_FINE) || (dp <= -DEADBAND_FINE);
        wc = !r_rep_vld[2] || (dw >= DEADBAND_FINE) || (dw <= -DEADBAND_FINE);

        // A faulted reading counts as zero for the alert and the bar.
        fault   = (os >= FAULT_LIMIT);
        alert   = !fault && (os >= ALERT_LIMIT);
        bar_on  = !fault && (os >= BAR_LOW);
        bar_u   = os - BAR_LOW;
        bar_sat = (bar_u >= BAR_RANGE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_w  <= '0;
            r_rep_p   <= '0;
            r_rep_w   <= '0;
            r_rep_o   <= '0;
            r_rep_pk  <= '0;
            r_rep_vld <= '0;
        end else if (r2_vld && e3) begin
            r_peak_w <= n_peak_w;
            if (oc) begin
                r_rep_o      <= os;
                r_rep_pk     <= r_peak_o;
                r_rep_vld[0] <= 1'b1;
            end
            if (pc) begin
                r_rep_p      <= ps;
                r_rep_vld[1] <= 1'b1;
            end
            if (wc) begin
                r_rep_w      <= sh_w;
                r_rep_vld[2] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e3) begin
            r3_ps      <= ps;
            r3_ws      <= sh_w;
            r3_os      <= os;
            r3_pk_o    <= r_peak_o;
            r3_pk_p    <= r_peak_p;
            r3_pk_w    <= n_peak_w;
            r3_oc      <= oc;
            r3_pc      <= pc;
            r3_wc      <= wc;
            r3_alert   <= alert;
            r3_fault   <= fault;
            r3_bar_on  <= bar_on;
            r3_bar_sat <= bar_sat;
            r3_bar_u   <= bar_u[BAR_U_W-1:0];
        end
    end

    // Stage 4: bar width, saturated at the span and at the field limit.
    always_comb begin
        bar_prod = r3_bar_u * BAR_MUL_W'(BAR_MUL);
        bar_q    = BAR_QX_W'(bar_prod[BAR_PROD_W-1:BAR_SHIFT]);
        if (!r3_bar_on) begin
            n_bar = '0;
        end else if (r3_bar_sat) begin
            n_bar = BAR_FULL;
        end else if (bar_q > BAR_QX_W'(255)) begin
            n_bar = 8'd255;
        end else begin
            n_bar = bar_q[BAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e4) begin
            r4_ps    <= r3_ps;
            r4_ws    <= r3_ws;
            r4_os    <= r3_os;
            r4_pk_o  <= r3_pk_o;
            r4_pk_p  <= r3_pk_p;
            r4_pk_w  <= r3_pk_w;
            r4_oc    <= r3_oc;
            r4_pc    <= r3_pc;
            r4_wc    <= r3_wc;
            r4_bar   <= n_bar;
            r4_alert <= r3_alert;
            r4_fault <= r3_fault;
        end
    end

    assign o_out_valid        = r4_vld;
    assign o_pressure_shown   = r4_ps;
    assign o_water_shown      = r4_ws;
    assign o_oil_shown        = r4_os;
    assign o_oil_peak_whole   = r4_pk_o;
    assign o_pressure_peak    = r4_pk_p;
    assign o_water_peak       = r4_pk_w;
    assign o_oil_changed      = r4_oc;
    assign o_pressure_changed = r4_pc;
    assign o_water_changed    = r4_wc;
    assign o_oil_bar_width    = r4_bar;
    assign o_oil_alert        = r4_alert;
    assign o_oil_fault        = r4_fault;

    // The seed flag never drops once an item has been smoothed.
    a_seed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeded |=> r_seeded)
        else $error("smoothing seed flag dropped");

    // The water peak never decreases.
    a_water_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_peak_w >= $past(r_peak_w)))
        else $error("water peak decreased");

    // A held stage 2 request is not lost.
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_vld && !e3) |=> r2_vld)
        else $error("stalled stage 2 request lost");

    // Once a request has passed change detection, every channel has a report.
    a_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld |-> (r_rep_vld == 3'b111))
        else $error("reported values not marked valid");

    // Alert and fault never show together, and the bar stays within its span.
    a_oil_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!(o_oil_alert && o_oil_fault) && (o_oil_bar_width <= BAR_FULL)))
        else $error("inconsistent oil flags or bar width");

endmodule

// ----- test/gauge_reading_checker.sv -----
`timescale 1ns / 100ps

// Watches the sample, result and configuration channels of the gauge block,
// predicts every result from the accepted requests and compares field by field.
module gauge_reading_checker #(
    parameter int BAR_SPAN_PIXELS = 210
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Sample channel
    input  logic                                     i_in_valid,
    input  logic                                     i_in_stall,
    input  logic        [gspcd_pkg::PRES_W-1:0]      i_pressure_avg,
    input  logic signed [gspcd_pkg::TEMP_W-1:0]      i_water_avg,
    input  logic signed [gspcd_pkg::TEMP_W-1:0]      i_oil_avg,
    // Result channel
    input  logic                                     i_out_valid,
    input  logic                                     i_out_stall,
    input  logic        [gspcd_pkg::PRES_W-1:0]      i_pressure_shown,
    input  logic signed [gspcd_pkg::TEMP_W-1:0]      i_water_shown,
    input  logic signed [gspcd_pkg::TEMP_W-1:0]      i_oil_shown,
    input  logic        [gspcd_pkg::WHOLE_W-1:0]     i_oil_peak_whole,
    input  logic        [gspcd_pkg::PRES_W-1:0]      i_pressure_peak,
    input  logic        [gspcd_pkg::PEAK_W_W-1:0]    i_water_peak,
    input  logic                                     i_oil_changed,
    input  logic                                     i_pressure_changed,
    input  logic                                     i_water_changed,
    input  logic        [gspcd_pkg::BAR_W-1:0]       i_oil_bar_width,
    input  logic                                     i_oil_alert,
    input  logic                                     i_oil_fault,
    // Configuration write channel
    input  logic                                     i_cfg_valid,
    input  logic                                     i_cfg_ready,
    input  gspcd_pkg::t_cfg_idx                      i_cfg_index,
    input  logic        [gspcd_pkg::ALPHA_W-1:0]     i_cfg_data,
    // Status for the stimulus side
    output int                                       o_fail_count,
    output int                                       o_pending
);
    import gspcd_pkg::*;

    // One result as the block presents it, in port order.
    typedef struct packed {
        logic        [PRES_W-1:0]   pressure_shown;
        logic signed [TEMP_W-1:0]   water_shown;
        logic signed [TEMP_W-1:0]   oil_shown;
        logic        [WHOLE_W-1:0]  oil_peak_whole;
        logic        [PRES_W-1:0]   pressure_peak;
        logic        [PEAK_W_W-1:0] water_peak;
        logic                       oil_changed;
        logic                       pressure_changed;
        logic                       water_changed;
        logic        [BAR_W-1:0]    oil_bar_width;
        logic                       oil_alert;
        logic                       oil_fault;
    } t_gauge_reading;

    // Our copy of the configuration registers.
    logic [ALPHA_W-1:0] pres_alpha;
    logic [PRES_W-1:0]  pres_ceiling;
    logic               oil_present;

    // Smoother state in hundredths with 8 fraction bits, peaks and last reports.
    int sm_pres, sm_water, sm_oil;
    bit seeded;
    int pk_pres, pk_water, pk_oil_whole;
    int rep_pres, rep_water, rep_oil, rep_oil_peak;
    bit rep_pres_ok, rep_water_ok, rep_oil_ok;

    t_gauge_reading readings_due[$];
    int             mismatches = 0;

    // One smoothing step: s += round(alpha * (x*256 - s) / 65536), ties upward.
    function automatic int ema_step(int s, int x, int coef);
        longint diff, prod;
        diff = longint'(x) * 256 - longint'(s);
        prod = longint'(coef) * diff + 32768;
        return int'(longint'(s) + (prod >>> 16));
    endfunction

    // Drop the 8 fraction bits, rounding to nearest with ties upward.
    function automatic int to_hundredths(int s);
        return (s + 128) >>> 8;
    endfunction

    function automatic int distance(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advance the gauge state by one sample and work out the result it gives.
    task automatic predict_reading(
        input  logic        [PRES_W-1:0] p_in,
        input  logic signed [TEMP_W-1:0] w_in,
        input  logic signed [TEMP_W-1:0] o_in,
        output t_gauge_reading           r
    );
        int p, w, o, ps, ws, os, t, bar, whole;
        bit oc, pc, wc, fault;
        p = p_in;
        w = w_in;
        o = o_in;
        if (p > pres_ceiling) begin
            p = pres_ceiling;
        end

        // The first sample after reset seeds all three smoothers.
        if (!seeded) begin
            sm_pres  = p * 256;
            sm_water = w * 256;
            sm_oil   = o * 256;
            seeded   = 1'b1;
        end
        sm_pres  = ema_step(sm_pres, p, pres_alpha);
        sm_water = ema_step(sm_water, w, ALPHA_TEMP);
        sm_oil   = ema_step(sm_oil, o, ALPHA_TEMP);

        ps = to_hundredths(sm_pres);
        ws = to_hundredths(sm_water);
        os = oil_present ? to_hundredths(sm_oil) : 0;

        // Peaks: raw clamped pressure, smoothed water, whole-degree raw oil.
        if (p > pk_pres) begin
            pk_pres = p;
        end
        if (ws > pk_water) begin
            pk_water = ws;
        end
        if (o < FAULT_LIMIT) begin
            whole = o / 100;
            if (whole > pk_oil_whole) begin
                pk_oil_whole = whole;
            end
        end

        // Deadband change detection against the last reported values.
        oc = !rep_oil_ok || distance(os, rep_oil) >= DEADBAND_OIL ||
             pk_oil_whole != rep_oil_peak;
        pc = !rep_pres_ok || distance(ps, rep_pres) >= DEADBAND_FINE;
        wc = !rep_water_ok || distance(ws, rep_water) >= DEADBAND_FINE;
        if (oc) begin
            rep_oil      = os;
            rep_oil_peak = pk_oil_whole;
            rep_oil_ok   = 1'b1;
        end
        if (pc) begin
            rep_pres    = ps;
            rep_pres_ok = 1'b1;
        end
        if (wc) begin
            rep_water    = ws;
            rep_water_ok = 1'b1;
        end

        // A faulted reading counts as zero for the bar and the alert.
        fault = os >= FAULT_LIMIT;
        t     = fault ? 0 : os;
        bar   = 0;
        if (t >= BAR_LOW) begin
            bar = BAR_SPAN_PIXELS * (t - BAR_LOW) / BAR_RANGE;
            if (bar > BAR_SPAN_PIXELS) begin
                bar = BAR_SPAN_PIXELS;
            end
            if (bar > 255) begin
                bar = 255;
            end
        end

        r.pressure_shown   = PRES_W'(ps);
        r.water_shown      = TEMP_W'(ws);
        r.oil_shown        = TEMP_W'(os);
        r.oil_peak_whole   = WHOLE_W'(pk_oil_whole);
        r.pressure_peak    = PRES_W'(pk_pres);
        r.water_peak       = PEAK_W_W'(pk_water);
        r.oil_changed      = oc;
        r.pressure_changed = pc;
        r.water_changed    = wc;
        r.oil_bar_width    = BAR_W'(bar);
        r.oil_alert        = !fault && t >= ALERT_LIMIT;
        r.oil_fault        = fault;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
            end
        end
    endtask

    task automatic compare_reading(input t_gauge_reading want, input t_gauge_reading got);
        check_field("pressure_shown", want.pressure_shown, got.pressure_shown);
        check_field("water_shown", want.water_shown, got.water_shown);
        check_field("oil_shown", want.oil_shown, got.oil_shown);
        check_field("oil_peak_whole", want.oil_peak_whole, got.oil_peak_whole);
        check_field("pressure_peak", want.pressure_peak, got.pressure_peak);
        check_field("water_peak", want.water_peak, got.water_peak);
        check_field("oil_changed", want.oil_changed, got.oil_changed);
        check_field("pressure_changed", want.pressure_changed, got.pressure_changed);
        check_field("water_changed", want.water_changed, got.water_changed);
        check_field("oil_bar_width", want.oil_bar_width, got.oil_bar_width);
        check_field("oil_alert", want.oil_alert, got.oil_alert);
        check_field("oil_fault", want.oil_fault, got.oil_fault);
    endtask

    // Everything is sampled at the rising edge, before the edge's own updates.
    always @(posedge i_clk) begin : watch
        t_gauge_reading want, got, fresh;
        if (!i_rst_n) begin
            pres_alpha   = ALPHA_RESET;
            pres_ceiling = PMAX_RESET;
            oil_present  = 1'b1;
            sm_pres      = 0;
            sm_water     = 0;
            sm_oil       = 0;
            seeded       = 1'b0;
            pk_pres      = 0;
            pk_water     = 0;
            pk_oil_whole = 0;
            rep_pres     = 0;
            rep_water    = 0;
            rep_oil      = 0;
            rep_oil_peak = 0;
            rep_pres_ok  = 1'b0;
            rep_water_ok = 1'b0;
            rep_oil_ok   = 1'b0;
            readings_due.delete();
        end else begin
            // Register writes; an unused index changes nothing.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ALPHA:   pres_alpha   = i_cfg_data;
                    CFG_PMAX:    pres_ceiling = i_cfg_data[PRES_W-1:0];
                    CFG_PRESENT: oil_present  = i_cfg_data[0];
                    default: ;
                endcase
            end

            // A result is matched against the oldest outstanding request.
            if (i_out_valid && !i_out_stall) begin
                got = {i_pressure_shown, i_water_shown, i_oil_shown, i_oil_peak_whole,
                       i_pressure_peak, i_water_peak, i_oil_changed, i_pressure_changed,
                       i_water_changed, i_oil_bar_width, i_oil_alert, i_oil_fault};
                if (readings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t ns: result with no request outstanding", $time);
                    end
                end else begin
                    want = readings_due.pop_front();
                    compare_reading(want, got);
                end
            end

            if (i_in_valid && !i_in_stall) begin
                predict_reading(i_pressure_avg, i_water_avg, i_oil_avg, fresh);
                readings_due.push_back(fresh);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= readings_due.size();
    end

endmodule

// ----- test/gauge_smooth_peak_change_detect_test.sv -----
`timescale 1ns / 100ps

module gauge_smooth_peak_change_detect_test;
    import gspcd_pkg::*;

    localparam int       BAR_SPAN          = 210;
    localparam int       NUM_PHASES        = 6;
    localparam int       SAMPLES_PER_PHASE = 90;
    localparam t_cfg_idx CFG_SPARE         = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Sample channel
    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    logic        [PRES_W-1:0] pressure_avg = '0;
    logic signed [TEMP_W-1:0] water_avg    = '0;
    logic signed [TEMP_W-1:0] oil_avg      = '0;

    // Result channel
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic        [PRES_W-1:0]   pressure_shown;
    logic signed [TEMP_W-1:0]   water_shown;
    logic signed [TEMP_W-1:0]   oil_shown;
    logic        [WHOLE_W-1:0]  oil_peak_whole;
    logic        [PRES_W-1:0]   pressure_peak;
    logic        [PEAK_W_W-1:0] water_peak;
    logic                       oil_changed;
    logic                       pressure_changed;
    logic                       water_changed;
    logic        [BAR_W-1:0]    oil_bar_width;
    logic                       oil_alert;
    logic                       oil_fault;

    // Configuration channel
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    t_cfg_idx           cfg_index = CFG_ALPHA;
    logic [ALPHA_W-1:0] cfg_data  = '0;

    // Idling controls and checker status.
    bit stall_on = 1'b0;
    bit gaps_on  = 1'b0;
    int fail_count;
    int pending;

    initial begin
        forever #4 clk = ~clk;
    end

    gauge_smooth_peak_change_detect #(
        .BAR_SPAN_PIXELS(BAR_SPAN)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_pressure_avg     (pressure_avg),
        .i_water_avg        (water_avg),
        .i_oil_avg          (oil_avg),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_pressure_shown   (pressure_shown),
        .o_water_shown      (water_shown),
        .o_oil_shown        (oil_shown),
        .o_oil_peak_whole   (oil_peak_whole),
        .o_pressure_peak    (pressure_peak),
        .o_water_peak       (water_peak),
        .o_oil_changed      (oil_changed),
        .o_pressure_changed (pressure_changed),
        .o_water_changed    (water_changed),
        .o_oil_bar_width    (oil_bar_width),
        .o_oil_alert        (oil_alert),
        .o_oil_fault        (oil_fault),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    gauge_reading_checker #(
        .BAR_SPAN_PIXELS(BAR_SPAN)
    ) u_reading_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_pressure_avg     (pressure_avg),
        .i_water_avg        (water_avg),
        .i_oil_avg          (oil_avg),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_pressure_shown   (pressure_shown),
        .i_water_shown      (water_shown),
        .i_oil_shown        (oil_shown),
        .i_oil_peak_whole   (oil_peak_whole),
        .i_pressure_peak    (pressure_peak),
        .i_water_peak       (water_peak),
        .i_oil_changed      (oil_changed),
        .i_pressure_changed (pressure_changed),
        .i_water_changed    (water_changed),
        .i_oil_bar_width    (oil_bar_width),
        .i_oil_alert        (oil_alert),
        .i_oil_fault        (oil_fault),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // The result side stalls in random bursts while enabled.
    initial begin
        forever begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic int jitter(int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Present one request, possibly after an idle gap, and hold it until taken.
    task automatic send_sample(
        input logic        [PRES_W-1:0] p,
        input logic signed [TEMP_W-1:0] w,
        input logic signed [TEMP_W-1:0] o
    );
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        pressure_avg <= p;
        water_avg    <= w;
        oil_avg      <= o;
        do @(posedge clk); while (in_stall);
    endtask

    // Keep the sender quiet until every outstanding request has its result.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Leaves the write request raised; the caller lowers it after the last write.
    task automatic write_reg(input t_cfg_idx idx, input logic [ALPHA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // A hold of near-steady, possibly drifting readings lets the smoothers settle
    // on the thresholds and exercises the deadbands; a few requests are pure noise.
    task automatic hold_run(input int count);
        int pres, water, oil, spread, slope;
        pres  = $urandom_range(0, 2047);
        water = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                            : int'($urandom_range(0, 29000)) - 4000;
        case ($urandom_range(0, 7))
            0: oil = 8000;
            1: oil = 12000;
            2: oil = 13000;
            3: oil = 19900;
            4: oil = 19899;
            5: oil = int'($urandom_range(0, 65535)) - 32768;
            default: oil = int'($urandom_range(0, 29000)) - 4000;
        endcase
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 3;
            2: spread = 12;
            default: spread = 300;
        endcase
        slope = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 40)) - 20 : 0;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_sample(PRES_W'($urandom), TEMP_W'($urandom), TEMP_W'($urandom));
            end else begin
                send_sample(PRES_W'(pres + jitter(spread)), TEMP_W'(water + jitter(spread)),
                            TEMP_W'(oil + jitter(spread)));
            end
            water += slope;
            oil   += slope;
        end
    endtask

    initial begin : stimulus
        // Corner requests: the first one seeds the smoothers exactly, so it sits
        // right on the fault limit with a pressure above the ceiling.
        logic        [PRES_W-1:0] corner_pres  [12] = '{2047, 0, 2000, 1999, 0, 2047,
                                                       1024, 1, 5, 10, 15, 2000};
        logic signed [TEMP_W-1:0] corner_water [12] = '{25000, -4000, 32767, -32768, 0, -1,
                                                       100, -100, 5000, 5004, 5010, 25000};
        logic signed [TEMP_W-1:0] corner_oil   [12] = '{19900, 19899, 12000, 8000, 13000,
                                                       -150, 32767, -32768, 7999, 19899,
                                                       19899, 199};
        int  phase_sent;
        int  run_len;
        bit  last;

        repeat (12) @(posedge clk);
        rst_n    <= 1'b1;
        stall_on <= 1'b1;
        @(posedge clk);

        foreach (corner_pres[k]) begin
            send_sample(corner_pres[k], corner_water[k], corner_oil[k]);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Registers change only with the block drained.
            wait_for_results();
            case (phase)
                0: begin
                    write_reg(CFG_ALPHA, 16'hFFFF);
                    write_reg(CFG_PMAX, 16'd2000);
                    write_reg(CFG_PRESENT, 16'd1);
                end
                1: begin
                    // Upper data bits must be ignored: ceiling 0, sensor absent.
                    write_reg(CFG_ALPHA, 16'd0);
                    write_reg(CFG_PMAX, 16'hF800);
                    write_reg(CFG_PRESENT, 16'hFFFE);
                end
                2: begin
                    write_reg(CFG_ALPHA, 16'($urandom));
                    write_reg(CFG_PMAX, 16'($urandom_range(0, 2047)));
                    write_reg(CFG_PRESENT, 16'd1);
                end
                3: begin
                    write_reg(CFG_ALPHA, 16'd1);
                    write_reg(CFG_PMAX, 16'h07FF);
                    write_reg(CFG_PRESENT, 16'd0);
                end
                4: begin
                    write_reg(CFG_SPARE, 16'hFFFF);
                    write_reg(CFG_ALPHA, 16'h8000);
                    write_reg(CFG_PMAX, 16'd1000);
                    write_reg(CFG_PRESENT, 16'hFFFF);
                end
                default: begin
                    write_reg(CFG_ALPHA, ALPHA_RESET);
                    write_reg(CFG_PMAX, 16'(PMAX_RESET));
                    write_reg(CFG_PRESENT, 16'd1);
                end
            endcase
            cfg_valid <= 1'b0;

            // The last phase runs with both sides at full rate.
            last       = (phase == NUM_PHASES - 1);
            phase_sent = 0;
            while (phase_sent < SAMPLES_PER_PHASE) begin
                run_len = $urandom_range(8, 50);
                if (run_len > SAMPLES_PER_PHASE - phase_sent) begin
                    run_len = SAMPLES_PER_PHASE - phase_sent;
                end
                gaps_on  = !last && $urandom_range(0, 2) != 0;
                stall_on <= !last && $urandom_range(0, 2) != 0;
                hold_run(run_len);
                phase_sent += run_len;
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
